[rtl/dali_pkg.sv]
`timescale 1ns / 1ps

package dali_pkg;

  localparam int unsigned RX_BITS_DEF = 16;
  localparam int unsigned TX_BITS_DEF = 8;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TMR_W  = 2;

  localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXPIRY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEND   = 2'd2;

  localparam logic [TMR_W-1:0] TMR_STOP  = 2'd0;
  localparam logic [TMR_W-1:0] TMR_FIRST = 2'd1;
  localparam logic [TMR_W-1:0] TMR_RXBIT = 2'd2;
  localparam logic [TMR_W-1:0] TMR_HALF  = 2'd3;

  typedef struct packed {
    logic              tx_level;
    logic [TMR_W-1:0]  timer_action;
    logic              rx_valid;
    logic [WORD_W-1:0] rx_word;
    logic              aborted;
    logic              busy_res;
  } result_t;

endpackage

[rtl/dali_engine.sv]
`timescale 1ns / 1ps

module dali_engine #(
  parameter int unsigned RX_BITS = dali_pkg::RX_BITS_DEF,
  parameter int unsigned TX_BITS = dali_pkg::TX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [dali_pkg::CMD_W-1:0]    cmd_i,
  input  logic                          rx_level_i,
  input  logic [dali_pkg::BYTE_W-1:0]   send_byte_i,
  output dali_pkg::result_t             res_o
);
  import dali_pkg::*;

  localparam int unsigned BL_W = $clog2(RX_BITS + 1);
  localparam int unsigned PW   = $clog2(TX_BITS + 2);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } mode_e;

  mode_e              mode_q, mode_d;
  logic               edge_q, edge_d;
  logic [BL_W-1:0]    bits_q, bits_d;
  logic [RX_BITS-1:0] shift_q, shift_d;
  logic [TX_BITS-1:0] txd_q, txd_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic               half_q, half_d;
  logic               pin_q, pin_d;

  logic               busy;
  logic               valid, abort_flag;
  logic [WORD_W-1:0]  word_full;
  logic [TX_BITS-1:0] tx_sel;

  assign busy   = (mode_q == MODE_RX) || (mode_q == MODE_TX);
  assign tx_sel = txd_q >> (pos_q - PW'(1));

  if (RX_BITS >= WORD_W) begin : g_wide
    assign word_full = shift_d[WORD_W-1:0];
  end else begin : g_narrow
    assign word_full = {{(WORD_W - RX_BITS){1'b0}}, shift_d};
  end

  always_comb begin
    mode_d     = mode_q;
    edge_d     = edge_q;
    bits_d     = bits_q;
    shift_d    = shift_q;
    txd_d      = txd_q;
    pos_d      = pos_q;
    half_d     = half_q;
    pin_d      = pin_q;
    valid      = 1'b0;
    abort_flag = 1'b0;
    case (cmd_i)
      CMD_EDGE: begin
        if (!busy) begin
          mode_d  = MODE_RX;
          edge_d  = 1'b0;
          shift_d = '0;
          bits_d  = BL_W'(RX_BITS);
        end else begin
          edge_d = 1'b1;
        end
      end
      CMD_EXPIRY: begin
        if (mode_q == MODE_RX) begin
          if (edge_q) begin
            edge_d = 1'b0;
            if (bits_q != '0) bits_d = bits_q - BL_W'(1);
            shift_d = shift_q | (RX_BITS'(rx_level_i) << bits_d);
            if (bits_d == '0) begin
              valid  = 1'b1;
              mode_d = MODE_IDLE;
              pin_d  = 1'b0;
            end
          end else begin
            abort_flag = 1'b1;
            mode_d     = MODE_IDLE;
          end
        end else if (mode_q == MODE_TX) begin
          half_d = ~half_q;
          if (pos_q == '0) begin
            pin_d  = 1'b0;
            mode_d = MODE_IDLE;
          end else if (pos_q > PW'(TX_BITS)) begin
            if (half_d) begin
              pin_d = 1'b1;
            end else begin
              pin_d = 1'b0;
              pos_d = PW'(TX_BITS);
            end
          end else begin
            if (half_d) begin
              pin_d = tx_sel[0];
            end else begin
              pin_d = ~pin_q;
              pos_d = pos_q - PW'(1);
            end
          end
        end
      end
      CMD_SEND: begin
        if (!busy) begin
          mode_d = MODE_TX;
          txd_d  = TX_BITS'(send_byte_i);
          pos_d  = PW'(TX_BITS + 1);
          half_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.tx_level = pin_d;
    unique case (mode_d)
      MODE_RX: res_o.timer_action = (bits_d == BL_W'(RX_BITS)) ? TMR_FIRST : TMR_RXBIT;
      MODE_TX: res_o.timer_action = TMR_HALF;
      default: res_o.timer_action = TMR_STOP;
    endcase
    res_o.rx_valid = valid;
    res_o.rx_word  = valid ? word_full : '0;
    res_o.aborted  = abort_flag;
    res_o.busy_res = (mode_d == MODE_RX) || (mode_d == MODE_TX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      edge_q  <= 1'b0;
      bits_q  <= '0;
      shift_q <= '0;
      txd_q   <= '0;
      pos_q   <= '0;
      half_q  <= 1'b0;
      pin_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      edge_q  <= edge_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      txd_q   <= txd_d;
      pos_q   <= pos_d;
      half_q  <= half_d;
      pin_q   <= pin_d;
    end
  end

endmodule

[rtl/dali_manchester_transceiver_unit.sv]
// DALI Manchester line engine. Each input item is one line event (receive
// edge, bit-timer expiry or send request); each yields exactly one result
// item with the transmit pin level, the timer reload code, frame/abort flags
// and busy. The state update is a single combinational step between the
// engine state registers and the result register, so items may be
// accepted in every cycle while the result side keeps up. in_ready_o stays
// high whenever the result register is empty or being taken in the same
// cycle.
`timescale 1ns / 1ps

module dali_manchester_transceiver_unit #(
  parameter int unsigned RX_BITS = dali_pkg::RX_BITS_DEF,
  parameter int unsigned TX_BITS = dali_pkg::TX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dali_pkg::CMD_W-1:0]    cmd_i,
  input  logic                          rx_level_i,
  input  logic [dali_pkg::BYTE_W-1:0]   send_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          tx_level_o,
  output logic [dali_pkg::TMR_W-1:0]    timer_action_o,
  output logic                          rx_valid_o,
  output logic [dali_pkg::WORD_W-1:0]   rx_word_o,
  output logic                          aborted_o,
  output logic                          busy_res_o
);
  import dali_pkg::*;

  logic    accept;
  logic    out_valid_q;
  result_t res_d, res_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  dali_engine #(
    .RX_BITS(RX_BITS),
    .TX_BITS(TX_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .cmd_i      (cmd_i),
    .rx_level_i (rx_level_i),
    .send_byte_i(send_byte_i),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tx_level_o     = res_q.tx_level;
  assign timer_action_o = res_q.timer_action;
  assign rx_valid_o     = res_q.rx_valid;
  assign rx_word_o      = res_q.rx_word;
  assign aborted_o      = res_q.aborted;
  assign busy_res_o     = res_q.busy_res;

endmodule

[rtl/dali_checker.sv]
`timescale 1ns / 1ps

module dali_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          tx_level_o,
  input logic [dali_pkg::TMR_W-1:0]    timer_action_o,
  input logic                          rx_valid_o,
  input logic [dali_pkg::WORD_W-1:0]   rx_word_o,
  input logic                          aborted_o,
  input logic                          busy_res_o
);
  import dali_pkg::*;

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_word_o)
      && $stable(timer_action_o) && $stable(tx_level_o))
    else $error("result item changed while stalled");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("not ready with empty output");

  a_frame_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_valid_o |-> !aborted_o && !busy_res_o && !tx_level_o
      && timer_action_o == TMR_STOP)
    else $error("frame completion left engine active");

  a_abort_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && aborted_o |-> !busy_res_o && timer_action_o == TMR_STOP
      && rx_word_o == '0)
    else $error("abort left engine active");

endmodule

bind dali_manchester_transceiver_unit dali_checker u_dali_checker (.*);

[tb/sv/tb_dali_manchester_transceiver_unit.sv]
`timescale 1ns / 1ps

module tb_dali_manchester_transceiver_unit;
  import dali_pkg::*;

  localparam int unsigned RX_BITS = RX_BITS_DEF;
  localparam int unsigned TX_BITS = TX_BITS_DEF;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } line_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  cmd_i = CMD_NONE;
  logic              rx_level_i = 1'b0;
  logic [BYTE_W-1:0] send_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              tx_level_o;
  logic [TMR_W-1:0]  timer_action_o;
  logic              rx_valid_o;
  logic [WORD_W-1:0] rx_word_o;
  logic              aborted_o;
  logic              busy_res_o;

  // line engine state as predicted
  line_mode_e  mode = MODE_IDLE;
  bit          edge_flag = 1'b0;
  int unsigned bits_rem = 0;
  logic [31:0] rx_acc = '0;
  logic [7:0]  tx_byte = '0;
  int unsigned tx_sym = 0;
  bit          half = 1'b0;
  bit          pin = 1'b0;

  result_t     expected_results[$];
  result_t     exp_r;
  int unsigned error_count = 0;
  int unsigned events_applied = 0;
  bit          src_idle_en = 1'b0;
  bit          sink_idle_en = 1'b0;

  dali_manchester_transceiver_unit #(
    .RX_BITS(RX_BITS),
    .TX_BITS(TX_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .rx_level_i     (rx_level_i),
    .send_byte_i    (send_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tx_level_o     (tx_level_o),
    .timer_action_o (timer_action_o),
    .rx_valid_o     (rx_valid_o),
    .rx_word_o      (rx_word_o),
    .aborted_o      (aborted_o),
    .busy_res_o     (busy_res_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic result_t predict_line_event(logic [CMD_W-1:0] cmd, logic lvl,
                                                 logic [7:0] byte_v);
    result_t     r;
    logic [31:0] data_w;
    int unsigned idx;
    r = '0;
    case (cmd)
      CMD_EDGE: begin
        if (mode == MODE_IDLE) begin
          mode = MODE_RX;
          edge_flag = 1'b0;
          rx_acc = '0;
          bits_rem = RX_BITS;
        end else begin
          edge_flag = 1'b1;
        end
      end
      CMD_EXPIRY: begin
        if (mode == MODE_RX) begin
          if (edge_flag) begin
            edge_flag = 1'b0;
            if (bits_rem > 0) bits_rem--;
            if (lvl && bits_rem < 32) rx_acc[bits_rem] = 1'b1;
            if (bits_rem == 0) begin
              r.rx_valid = 1'b1;
              r.rx_word = rx_acc[15:0];
              mode = MODE_IDLE;
              pin = 1'b0;
            end
          end else begin
            r.aborted = 1'b1;
            mode = MODE_IDLE;
          end
        end else if (mode == MODE_TX) begin
          half = ~half;
          if (tx_sym == 0) begin
            pin = 1'b0;
            mode = MODE_IDLE;
          end else if (tx_sym > TX_BITS) begin
            if (half) begin
              pin = 1'b1;
            end else begin
              pin = 1'b0;
              tx_sym = TX_BITS;
            end
          end else begin
            data_w = 32'(tx_byte);
            idx = (tx_sym - 1) % 32;
            if (half) begin
              pin = data_w[idx];
            end else begin
              pin = ~pin;
              tx_sym--;
            end
          end
        end
      end
      CMD_SEND: begin
        if (mode == MODE_IDLE) begin
          mode = MODE_TX;
          tx_byte = byte_v;
          tx_sym = TX_BITS + 1;
          half = 1'b0;
        end
      end
      default: ;
    endcase
    r.tx_level = pin;
    case (mode)
      MODE_RX: r.timer_action = (bits_rem == RX_BITS) ? TMR_FIRST : TMR_RXBIT;
      MODE_TX: r.timer_action = TMR_HALF;
      default: r.timer_action = TMR_STOP;
    endcase
    r.busy_res = (mode == MODE_RX || mode == MODE_TX);
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic apply_event(input logic [CMD_W-1:0] cmd, input logic lvl,
                             input logic [7:0] byte_v);
    if (src_idle_en && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    rx_level_i  <= lvl;
    send_byte_i <= byte_v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    events_applied++;
    expected_results.push_back(predict_line_event(cmd, lvl, byte_v));
    @(negedge clk_i);
  endtask

  task automatic settle_idle();
    while (mode != MODE_IDLE)
      apply_event(CMD_EXPIRY, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic random_noise_event();
    apply_event(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)));
  endtask

  task automatic random_forward_frame();
    int unsigned style;
    int unsigned b;
    logic        lvl;
    settle_idle();
    style = $urandom_range(0, 5);
    apply_event(CMD_EDGE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    for (b = 0; b < RX_BITS; b++) begin
      // missing edge: drops the frame
      if ($urandom_range(0, 99) < 3) begin
        apply_event(CMD_EXPIRY, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        return;
      end
      apply_event(CMD_EDGE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 5) begin
        apply_event($urandom_range(0, 1) ? CMD_SEND : CMD_NONE, 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 3) apply_event(CMD_EDGE, 1'b0, 8'h00);
      lvl = (style == 0) ? 1'b0 : (style == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      apply_event(CMD_EXPIRY, lvl, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_backward_send();
    int unsigned style;
    logic [7:0]  data_v;
    settle_idle();
    style = $urandom_range(0, 5);
    data_v = (style == 0) ? 8'h00 : (style == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    apply_event(CMD_SEND, 1'($urandom_range(0, 1)), data_v);
    while (mode == MODE_TX) begin
      if ($urandom_range(0, 99) < 8) random_noise_event();
      if (mode == MODE_TX)
        apply_event(CMD_EXPIRY, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_traffic(input int unsigned target);
    int unsigned goal;
    int unsigned pick;
    goal = events_applied + target;
    while (events_applied < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        random_forward_frame();
      end else if (pick < 85) begin
        random_backward_send();
      end else begin
        repeat ($urandom_range(1, 4)) random_noise_event();
      end
    end
  endtask

  task automatic test_idle_events();
    apply_event(CMD_EXPIRY, 1'b1, 8'hFF);
    apply_event(CMD_NONE, 1'b1, 8'hFF);
    apply_event(CMD_EXPIRY, 1'b0, 8'h00);
  endtask

  task automatic test_receive_abort();
    apply_event(CMD_EDGE, 1'b0, 8'h00);
    apply_event(CMD_SEND, 1'b0, 8'hA5);
    apply_event(CMD_NONE, 1'b0, 8'h00);
    apply_event(CMD_EDGE, 1'b1, 8'h00);
    apply_event(CMD_EXPIRY, 1'b1, 8'h00);
    apply_event(CMD_EDGE, 1'b0, 8'h00);
    apply_event(CMD_EDGE, 1'b1, 8'h00);
    apply_event(CMD_EXPIRY, 1'b0, 8'h00);
    apply_event(CMD_EXPIRY, 1'b1, 8'h00);
  endtask

  task automatic test_send_overlap();
    apply_event(CMD_SEND, 1'b1, 8'hFF);
    apply_event(CMD_EDGE, 1'b1, 8'h00);
    apply_event(CMD_SEND, 1'b0, 8'h00);
    apply_event(CMD_NONE, 1'b1, 8'h55);
    repeat (4) apply_event(CMD_EXPIRY, 1'b1, 8'h00);
    apply_event(CMD_EDGE, 1'b0, 8'hFF);
    apply_event(CMD_EXPIRY, 1'b0, 8'h00);
  endtask

  task automatic test_random_with_gaps();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    run_random_traffic(600);
  endtask

  task automatic test_random_back_to_back();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    run_random_traffic(250);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= sink_idle_en ? ($urandom_range(0, 99) >= 10) : 1'b1;
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual tx=%0b tmr=%0d word=0x%0h",
                 $time, tx_level_o, timer_action_o, rx_word_o);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("tx_level", 32'(exp_r.tx_level), 32'(tx_level_o));
        check_field("timer_action", 32'(exp_r.timer_action), 32'(timer_action_o));
        check_field("rx_valid", 32'(exp_r.rx_valid), 32'(rx_valid_o));
        check_field("rx_word", 32'(exp_r.rx_word), 32'(rx_word_o));
        check_field("aborted", 32'(exp_r.aborted), 32'(aborted_o));
        check_field("busy_res", 32'(exp_r.busy_res), 32'(busy_res_o));
      end
    end
  end

  initial begin
    int unsigned wait_cycles;
    sink_idle_en = 1'b1;
    src_idle_en = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_events();
    test_receive_abort();
    test_send_overlap();
    test_random_with_gaps();
    test_random_back_to_back();

    in_valid_i <= 1'b0;
    for (wait_cycles = 0; expected_results.size() != 0 && wait_cycles < 2000; wait_cycles++)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d result items missing, expected 0, actual %0d", $time,
               expected_results.size(), expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
